@@ rtl/core/ntp_pkg.sv @@
// ----------------------------------------------------------------------------
// ntp_pkg
// Shared types and code constants for the nybble text packer.
// ----------------------------------------------------------------------------
package ntp_pkg;

  // command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [7:0] NYB_LIMIT   = 8'd14;
  localparam logic [7:0] SHORT_LIMIT = 8'd27;
  localparam logic [7:0] SHORT_BASE  = 8'hF1;
  localparam logic [7:0] LONG_MORE   = 8'hFF;
  localparam logic [7:0] LONG_LAST   = 8'hFE;
  localparam logic [3:0] ESC_NYB     = 4'hF;
  localparam logic [7:0] EXT_LIMIT   = 8'h80;
  localparam logic [7:0] END_BYTE    = 8'h00;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_code;
    logic [7:0] rank;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_word;
    logic       range_error;
  } out_item_t;

  // one classified character: one or two bytes to send
  typedef struct packed {
    logic      two;
    out_item_t b0;
    out_item_t b1;
  } job_t;

endpackage

@@ rtl/core/ntp_front.sv @@
// ----------------------------------------------------------------------------
// ntp_front
// Accepts items, keeps the rank table and classifies each character into a
// job of zero, one or two output bytes, tracking the pending nybble.
// ----------------------------------------------------------------------------
module ntp_front import ntp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_job,
  input  logic     q_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [11:0] DEPTH12 = 12'(TABLE_DEPTH);

  logic [7:0]    mem [TABLE_DEPTH];
  logic [7:0]    rd_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_cmd_r;
  logic          s1_last_r;
  logic          pend_r, pend_nxt;
  logic [3:0]    nyb_r, nyb_nxt;
  logic [11:0]   rem;
  logic [AW-1:0] addr;
  logic          accept;
  logic          s1_go;
  logic          has_out;
  job_t          job;
  logic [3:0]    nib;

  // address modulo table depth, restoring subtract (handles a quotient of at most 15)
  always_comb begin
    rem = {4'b0, in_data.char_code};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (DEPTH12 << k)) begin
        rem = rem - (DEPTH12 << k);
      end
    end
    addr = rem[AW-1:0];
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_data.cmd == CMD_WRITE) begin
        mem[addr] <= in_data.rank;
      end else begin
        rd_r <= mem[addr];
      end
    end
  end

  // classify the character held in stage one
  always_comb begin
    nib      = rd_r[3:0] + 4'd1;
    job      = '0;
    has_out  = 1'b0;
    pend_nxt = pend_r;
    nyb_nxt  = nyb_r;
    if (rd_r < NYB_LIMIT) begin
      if (pend_r) begin
        has_out     = 1'b1;
        job.b0.out_byte = {nyb_r, nib};
        pend_nxt    = 1'b0;
        if (s1_last_r) begin
          job.two = 1'b1;
          job.b1.out_byte = END_BYTE;
          job.b1.end_of_word = 1'b1;
        end
      end else if (s1_last_r) begin
        has_out = 1'b1;
        job.b0.out_byte = {nib, 4'h0};
        job.b0.end_of_word = 1'b1;
      end else begin
        pend_nxt = 1'b1;
        nyb_nxt  = nib;
      end
    end else if (pend_r) begin
      has_out  = 1'b1;
      pend_nxt = 1'b0;
      job.b0.out_byte = {nyb_r, ESC_NYB};
      if (rd_r >= EXT_LIMIT) begin
        job.b0.range_error = 1'b1;
        if (s1_last_r) begin
          job.two = 1'b1;
          job.b1.out_byte = END_BYTE;
          job.b1.end_of_word = 1'b1;
        end
      end else begin
        job.two = 1'b1;
        job.b1.out_byte = {rd_r[6:0], !s1_last_r};
        job.b1.end_of_word = s1_last_r;
      end
    end else if (rd_r < SHORT_LIMIT) begin
      has_out = 1'b1;
      job.b0.out_byte = SHORT_BASE + (rd_r - NYB_LIMIT);
      if (s1_last_r) begin
        job.two = 1'b1;
        job.b1.out_byte = END_BYTE;
        job.b1.end_of_word = 1'b1;
      end
    end else begin
      has_out = 1'b1;
      job.two = 1'b1;
      job.b0.out_byte = s1_last_r ? LONG_LAST : LONG_MORE;
      job.b1.out_byte = rd_r;
      job.b1.end_of_word = s1_last_r;
    end
    if (s1_cmd_r == CMD_WRITE) begin
      has_out  = 1'b0;
      pend_nxt = pend_r;
      nyb_nxt  = nyb_r;
    end
  end

  assign s1_go    = s1_valid_r && (!has_out || !q_full);
  assign in_stall = s1_valid_r && !s1_go;
  assign push     = s1_valid_r && has_out && !q_full;
  assign push_job = job;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_r     <= 1'b0;
      nyb_r      <= 4'h0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_go) begin
        pend_r <= pend_nxt;
        nyb_r  <= nyb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r  <= in_data.cmd;
      s1_last_r <= in_data.last_char;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && q_full)
    else $error("input stalled without a blocked item");

  a_word_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_cmd_r == CMD_ENCODE && s1_last_r) |=> !pend_r)
    else $error("nybble left pending after word end");

endmodule

@@ rtl/core/ntp_queue.sv @@
// ----------------------------------------------------------------------------
// ntp_queue
// Two-entry job queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module ntp_queue import ntp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from empty queue");

endmodule

@@ rtl/core/ntp_back.sv @@
// ----------------------------------------------------------------------------
// ntp_back
// Serializes queued jobs into single output bytes through an output register.
// ----------------------------------------------------------------------------
module ntp_back import ntp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      idx_r, idx_nxt;
  logic      load;

  // output register free or being drained this cycle
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && head_valid && (idx_r || !head_job.two);

  always_comb begin
    idx_nxt = idx_r;
    if (load && head_valid) begin
      idx_nxt = !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_data_r <= idx_r ? head_job.b1 : head_job.b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_second_byte_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> head_valid && head_job.two)
    else $error("second byte selected without a two-byte job");

endmodule

@@ rtl/core/nybble_text_packer_unit.sv @@
// ----------------------------------------------------------------------------
// nybble_text_packer_unit
// Packs words of characters into a nybble/byte coded stream using a
// loadable character-to-rank table.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_item_t (cmd, char, rank, last)
//  out_     output     out_valid/out_stall out_item_t (byte, eow, error)
//
//  an item is taken every cycle while the job queue has room; a character
//  yields up to two bytes and the serializer sends one byte per cycle while
//  out_stall is low, so two-byte characters are paced by the output port; an
//  item passes the stage-one table read, the job queue and the output register
//  reset clears the pending nybble, the queue and the output valid; the rank
//  table is not cleared and must be loaded before use
//  output stalls back up through the queue to in_stall; table writes and
//  characters that only leave a nybble pending pass without queue space
// ----------------------------------------------------------------------------
module nybble_text_packer_unit import ntp_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic push, q_full, head_valid, pop;
  job_t push_job, head_job;

  ntp_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  ntp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  ntp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nybble_text_packer_unit. It loads the rank table,
// runs a directed set of words through every coding form, then random words
// with table rewrites mixed in. A scoreboard predicts each packed byte and
// checks the output stream in order, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench import ntp_pkg::*;;

  localparam int TBL_DEPTH   = 256;
  localparam int RAND_ITEMS  = 600;
  localparam int CALM_ITEMS  = 100;
  localparam int DRAIN_WAIT  = 12;
  localparam int LIMIT_TICKS = 2_000_000;

  // predicts the packed byte stream and checks it in order
  class packed_byte_board;
    logic [7:0] rank_of [TBL_DEPTH];
    bit         nyb_held;
    logic [3:0] nyb_val;
    out_item_t  bytes_due [$];
    int         mismatches;
    int         checked;
    int         words;
    int         range_errs;

    function void push_byte(logic [7:0] b, logic eow, logic err);
      out_item_t o;
      o.out_byte    = b;
      o.end_of_word = eow;
      o.range_error = err;
      bytes_due.push_back(o);
    endfunction

    function void take_item(in_item_t it);
      int         addr;
      logic [7:0] r;
      logic [7:0] esc;
      addr = int'(it.char_code) % TBL_DEPTH;
      if (it.cmd == CMD_WRITE) begin
        rank_of[addr] = it.rank;
        return;
      end
      r = rank_of[addr];
      if (r < NYB_LIMIT) begin
        if (nyb_held) begin
          push_byte({nyb_val, 4'(r + 8'd1)}, 1'b0, 1'b0);
          nyb_held = 1'b0;
        end else begin
          nyb_val  = 4'(r + 8'd1);
          nyb_held = 1'b1;
        end
      end else if (nyb_held) begin
        esc      = {nyb_val, ESC_NYB};
        nyb_held = 1'b0;
        if (r >= EXT_LIMIT) begin
          push_byte(esc, 1'b0, 1'b1);
        end else begin
          push_byte(esc, 1'b0, 1'b0);
          push_byte({r[6:0], ~it.last_char}, it.last_char, 1'b0);
          if (it.last_char) return;
        end
      end else if (r < SHORT_LIMIT) begin
        push_byte(SHORT_BASE + (r - NYB_LIMIT), 1'b0, 1'b0);
      end else begin
        push_byte(it.last_char ? LONG_LAST : LONG_MORE, 1'b0, 1'b0);
        push_byte(r, it.last_char, 1'b0);
        if (it.last_char) return;
      end
      if (it.last_char) begin
        if (nyb_held) begin
          push_byte({nyb_val, 4'h0}, 1'b1, 1'b0);
          nyb_held = 1'b0;
        end else begin
          push_byte(END_BYTE, 1'b1, 1'b0);
        end
      end
    endfunction

    function void check_byte(out_item_t got);
      out_item_t want;
      checked++;
      if (got.end_of_word) words++;
      if (got.range_error) range_errs++;
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte %h eow %b err %b",
                   got.out_byte, got.end_of_word, got.range_error);
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte || got.end_of_word !== want.end_of_word ||
          got.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %h eow %b err %b, got byte %h eow %b err %b",
                   want.out_byte, want.end_of_word, want.range_error,
                   got.out_byte, got.end_of_word, got.range_error);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit        bursts_on = 1'b1;
  int        stall_left = 0;
  packed_byte_board board;

  logic [7:0] loaded_chars [$];
  bit         is_loaded [TBL_DEPTH];
  int         n_writes = 0;
  int         n_chars = 0;

  nybble_text_packer_unit #(.TABLE_DEPTH(TBL_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random receiver stall bursts
  always @(posedge clk) begin
    if (!rst_n || !bursts_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_byte(out_data);
  end

  function automatic in_item_t mk(logic cmd, logic [7:0] ch, logic [7:0] rk, logic last);
    in_item_t it;
    it.cmd       = cmd;
    it.char_code = ch;
    it.rank      = rk;
    it.last_char = last;
    return it;
  endfunction

  function automatic logic [7:0] pick_rank();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return 8'($urandom_range(0, 13));
    if (sel < 6) return 8'($urandom_range(14, 26));
    if (sel < 8) return 8'($urandom_range(27, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic send_item(in_item_t it);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge
    board.take_item(it);
    if (it.cmd == CMD_WRITE) begin
      n_writes++;
      if (!is_loaded[it.char_code]) begin
        is_loaded[it.char_code] = 1'b1;
        loaded_chars.push_back(it.char_code);
      end
    end else begin
      n_chars++;
    end
  endtask

  task automatic send_write(logic [7:0] ch, logic [7:0] rk);
    send_item(mk(CMD_WRITE, ch, rk, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_char(logic [7:0] ch, logic last);
    send_item(mk(CMD_ENCODE, ch, 8'($urandom_range(0, 255)), last));
  endtask

  initial begin
    #(LIMIT_TICKS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_item_t it;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table edges: nybble, short and long boundaries
    send_write(8'h00, 8'd0);
    send_write(8'hFF, 8'd13);
    send_write(8'h55, 8'd14);
    send_write(8'hAA, 8'd26);
    send_write(8'h0F, 8'd27);
    send_write(8'hF0, 8'd127);
    send_write(8'h80, 8'd128);
    send_write(8'h7F, 8'd255);
    send_write(8'h33, 8'd5);
    send_char(8'h00, 1'b0);          // nybble held
    send_char(8'hFF, 1'b0);          // nybble pair
    send_char(8'h55, 1'b0);          // short code
    send_char(8'hAA, 1'b1);          // short code, word end byte
    send_char(8'h0F, 1'b0);          // long code, more follows
    send_char(8'hF0, 1'b1);          // long code ends word
    send_char(8'h33, 1'b0);
    send_write(8'h33, 8'd7);         // table write keeps the held nybble
    send_char(8'h55, 1'b0);          // escape after held nybble
    send_char(8'h00, 1'b0);
    send_char(8'hF0, 1'b1);          // escape form ends word
    send_char(8'h33, 1'b0);
    send_char(8'h80, 1'b0);          // range error, no word end
    send_char(8'hFF, 1'b0);
    send_char(8'h7F, 1'b1);          // range error then end byte
    send_char(8'h00, 1'b1);          // lone nybble flushed at word end
    send_char(8'h80, 1'b1);          // high rank with nothing held

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0)
        bursts_on <= (i < RAND_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 12) begin
        it = mk(CMD_WRITE, 8'($urandom_range(0, 255)), pick_rank(),
                1'($urandom_range(0, 1)));
        send_item(it);
      end else begin
        send_char(loaded_chars[$urandom_range(0, loaded_chars.size() - 1)],
                  1'($urandom_range(0, 3) == 0));
      end
    end
    in_valid <= 1'b0;

    while (board.bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d items: %0d table writes, %0d characters",
             n_writes + n_chars, n_writes, n_chars);
    $display("checked %0d bytes over %0d words, %0d range errors seen",
             board.checked, board.words, board.range_errs);
    if (board.bytes_due.size() != 0)
      $display("%0d expected bytes never arrived", board.bytes_due.size());
    if (board.mismatches == 0 && board.bytes_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
